FILE: hdl/bitmap_font_glyph_blitter_top_defines.svh
// Assertion macros shared by the checker.
`ifndef BITMAP_FONT_GLYPH_BLITTER_TOP_DEFINES_SVH
`define BITMAP_FONT_GLYPH_BLITTER_TOP_DEFINES_SVH

// ante in this cycle implies cons in the same cycle
`define BFGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante in this cycle implies cons in the next cycle
`define BFGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bfgb_pkg.sv
`default_nettype none

package bfgb_pkg;

    localparam int MAX_CHAR_WIDTH  = 8;
    localparam int MAX_CHAR_HEIGHT = 8;
    localparam int GLYPH_COUNT     = 256;
    localparam int MAX_SCREEN_DIM  = 2048;

    localparam int STORE_DEPTH  = 16384;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int GLYPH_SHIFT  = $clog2(GLYPH_COUNT);
    localparam int WORD_W       = 32;
    localparam int CODE_W       = 8;
    localparam int POS_W        = 16;
    localparam int FB_ADDR_W    = 22;
    localparam int COLOUR_BITS  = 24;

    // raw register widths
    localparam int CFG_CHAR_W   = 4;
    localparam int CFG_SCR_W    = 12;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // clamped value widths
    localparam int CW_W  = $clog2(MAX_CHAR_WIDTH + 1);
    localparam int CH_W  = $clog2(MAX_CHAR_HEIGHT + 1);
    localparam int SCR_W = $clog2(MAX_SCREEN_DIM + 1);
    localparam int COL_W = (MAX_CHAR_WIDTH > 1) ? $clog2(MAX_CHAR_WIDTH) : 1;
    localparam int ROW_W = (MAX_CHAR_HEIGHT > 1) ? $clog2(MAX_CHAR_HEIGHT) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [1:0] {
        REG_CHAR_WIDTH    = 2'd0,
        REG_CHAR_HEIGHT   = 2'd1,
        REG_SCREEN_WIDTH  = 2'd2,
        REG_SCREEN_HEIGHT = 2'd3
    } reg_idx_t;

    localparam logic [CFG_CHAR_W-1:0] RST_CHAR_WIDTH    = CFG_CHAR_W'(8);
    localparam logic [CFG_CHAR_W-1:0] RST_CHAR_HEIGHT   = CFG_CHAR_W'(8);
    localparam logic [CFG_SCR_W-1:0]  RST_SCREEN_WIDTH  = CFG_SCR_W'(640);
    localparam logic [CFG_SCR_W-1:0]  RST_SCREEN_HEIGHT = CFG_SCR_W'(480);

    typedef enum logic {
        BK_IDLE,
        BK_DRAW
    } bk_state_t;

    // clamped configuration seen by front and back
    typedef struct packed {
        logic [CW_W-1:0]  cw;
        logic [CH_W-1:0]  ch;
        logic [SCR_W-1:0] sw;
        logic [SCR_W-1:0] sh;
    } cfg_t;

    // one queued item
    typedef struct packed {
        logic                    is_draw;
        logic [STORE_AW-1:0]     font_index;
        logic [WORD_W-1:0]       font_word;
        logic [CODE_W-1:0]       code;
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic                    use_colour;
        logic [WORD_W-1:0]       colour;
    } job_t;

    function automatic logic [CW_W-1:0] clamp_cw(input logic [CFG_CHAR_W-1:0] raw);
        logic [CW_W-1:0] res;
        if (raw == '0)
            res = CW_W'(1);
        else if (32'(raw) > MAX_CHAR_WIDTH)
            res = CW_W'(MAX_CHAR_WIDTH);
        else
            res = CW_W'(raw);
        return res;
    endfunction

    function automatic logic [CH_W-1:0] clamp_ch(input logic [CFG_CHAR_W-1:0] raw);
        logic [CH_W-1:0] res;
        if (raw == '0)
            res = CH_W'(1);
        else if (32'(raw) > MAX_CHAR_HEIGHT)
            res = CH_W'(MAX_CHAR_HEIGHT);
        else
            res = CH_W'(raw);
        return res;
    endfunction

    function automatic logic [SCR_W-1:0] clamp_scr(input logic [CFG_SCR_W-1:0] raw);
        logic [SCR_W-1:0] res;
        if (raw == '0)
            res = SCR_W'(1);
        else if (32'(raw) > MAX_SCREEN_DIM)
            res = SCR_W'(MAX_SCREEN_DIM);
        else
            res = SCR_W'(raw);
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bfgb_front.sv
`default_nettype none

module bfgb_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bfgb_pkg::cfg_t                  cfg,
    input  wire logic                            accept,
    input  wire logic                            op,
    input  wire logic [bfgb_pkg::STORE_AW-1:0]   font_index,
    input  wire logic [bfgb_pkg::WORD_W-1:0]     font_word,
    input  wire logic [bfgb_pkg::CODE_W-1:0]     char_code,
    input  wire logic                            first_char,
    input  wire logic signed [bfgb_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [bfgb_pkg::POS_W-1:0] pos_y,
    input  wire logic                            use_colour,
    input  wire logic [bfgb_pkg::WORD_W-1:0]     colour,
    output bfgb_pkg::job_t                       job
);

    logic signed [bfgb_pkg::POS_W-1:0] cursor_x_reg, cursor_x_next;
    logic signed [bfgb_pkg::POS_W-1:0] cursor_y_reg, cursor_y_next;
    logic signed [bfgb_pkg::POS_W-1:0] start_x, start_y;
    logic signed [bfgb_pkg::POS_W:0]   adv_x;

    always_comb
    begin
        start_x = first_char ? pos_x : cursor_x_reg;
        start_y = first_char ? pos_y : cursor_y_reg;
        adv_x   = {start_x[bfgb_pkg::POS_W-1], start_x}
                  + $signed({1'b0, (bfgb_pkg::POS_W)'(cfg.cw)});
        // only the upper limit can be crossed, the step is positive
        if (adv_x > $signed({2'b00, {(bfgb_pkg::POS_W-1){1'b1}}}))
            cursor_x_next = $signed({1'b0, {(bfgb_pkg::POS_W-1){1'b1}}});
        else
            cursor_x_next = adv_x[bfgb_pkg::POS_W-1:0];
        cursor_y_next = start_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (accept && op == bfgb_pkg::OP_DRAW)
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    always_comb
    begin
        job.is_draw    = (op == bfgb_pkg::OP_DRAW);
        job.font_index = font_index;
        job.font_word  = font_word;
        job.code       = char_code;
        job.cur_x      = start_x;
        job.cur_y      = start_y;
        job.use_colour = use_colour;
        job.colour     = colour;
    end

endmodule

`default_nettype wire

FILE: hdl/bfgb_queue.sv
`default_nettype none

module bfgb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bfgb_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output bfgb_pkg::job_t      head
);

    bfgb_pkg::job_t slot_reg [bfgb_pkg::QUEUE_DEPTH];
    logic [bfgb_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bfgb_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bfgb_pkg::QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        full       = (count_reg == bfgb_pkg::QCNT_W'(bfgb_pkg::QUEUE_DEPTH));
        head_valid = (count_reg != '0);
        head       = slot_reg[rd_ptr_reg];

        if (wr_ptr_reg == bfgb_pkg::QPTR_W'(bfgb_pkg::QUEUE_DEPTH - 1))
            wr_ptr_next = '0;
        else
            wr_ptr_next = wr_ptr_reg + 1'b1;

        if (rd_ptr_reg == bfgb_pkg::QPTR_W'(bfgb_pkg::QUEUE_DEPTH - 1))
            rd_ptr_next = '0;
        else
            rd_ptr_next = rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

FILE: hdl/bfgb_back.sv
`default_nettype none

module bfgb_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bfgb_pkg::cfg_t                   cfg,
    input  wire logic                             head_valid,
    input  wire bfgb_pkg::job_t                   head,
    output logic                                  pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  write_enable,
    output logic [bfgb_pkg::FB_ADDR_W-1:0]        fb_address,
    output logic [bfgb_pkg::WORD_W-1:0]           fb_pixel,
    output logic                                  last
);

    bfgb_pkg::bk_state_t state_reg, state_next;

    logic [bfgb_pkg::WORD_W-1:0] font_mem [bfgb_pkg::STORE_DEPTH];

    // current draw
    logic [bfgb_pkg::CODE_W-1:0]       code_reg;
    logic signed [bfgb_pkg::POS_W-1:0] org_x_reg, org_y_reg;
    logic                              use_col_reg;
    logic [bfgb_pkg::WORD_W-1:0]       colour_reg;
    logic [bfgb_pkg::COL_W-1:0]        col_reg;
    logic [bfgb_pkg::ROW_W-1:0]        row_reg;

    // read stage
    logic                              b_valid_reg;
    logic signed [bfgb_pkg::POS_W:0]   b_sx_reg, b_sy_reg;
    logic                              b_last_reg;
    logic                              b_use_col_reg;
    logic [bfgb_pkg::WORD_W-1:0]       b_colour_reg;
    logic [bfgb_pkg::WORD_W-1:0]       rd_word_reg;

    // output stage
    logic                              out_valid_reg;
    logic                              we_reg;
    logic [bfgb_pkg::FB_ADDR_W-1:0]    addr_reg;
    logic [bfgb_pkg::WORD_W-1:0]       pix_reg;
    logic                              last_reg;

    logic adv, issue, mem_we, job_load;
    logic col_end, row_end, pix_last;
    logic [bfgb_pkg::CODE_W+bfgb_pkg::CW_W-1:0]  base;
    logic [bfgb_pkg::ROW_W+bfgb_pkg::CW_W-1:0]   row_cw;
    logic [bfgb_pkg::STORE_AW-1:0]               glyph_addr;
    logic signed [bfgb_pkg::POS_W:0]             sx, sy;
    logic                                        on_x, on_y, vis;
    logic [2*bfgb_pkg::SCR_W-1:0]                prod;
    logic [bfgb_pkg::FB_ADDR_W-1:0]              fb_sum;

    // whole pipeline moves together, held while the output waits
    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        col_end  = (col_reg == bfgb_pkg::COL_W'(cfg.cw - 1'b1));
        row_end  = (row_reg == bfgb_pkg::ROW_W'(cfg.ch - 1'b1));
        pix_last = col_end && row_end;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfgb_pkg::BK_IDLE:
                if (head_valid && head.is_draw)
                    state_next = bfgb_pkg::BK_DRAW;
            bfgb_pkg::BK_DRAW:
                if (adv && pix_last)
                    state_next = bfgb_pkg::BK_IDLE;
            default:
                state_next = bfgb_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            bfgb_pkg::BK_IDLE: pop   = head_valid;
            bfgb_pkg::BK_DRAW: issue = adv;
            default: ;
        endcase
        mem_we   = pop && !head.is_draw;
        job_load = pop && head.is_draw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bfgb_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // pixel walk: rows inside columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (job_load)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (issue)
        begin
            if (row_end)
            begin
                row_reg <= '0;
                col_reg <= col_reg + 1'b1;
            end
            else
                row_reg <= row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            code_reg    <= head.code;
            org_x_reg   <= head.cur_x;
            org_y_reg   <= head.cur_y;
            use_col_reg <= head.use_colour;
            colour_reg  <= head.colour;
        end
    end

    always_comb
    begin
        base       = {{bfgb_pkg::CW_W{1'b0}}, code_reg}
                   * {{bfgb_pkg::CODE_W{1'b0}}, cfg.cw};
        row_cw     = {{bfgb_pkg::CW_W{1'b0}}, row_reg}
                   * {{bfgb_pkg::ROW_W{1'b0}}, cfg.cw};
        glyph_addr = bfgb_pkg::STORE_AW'(base)
                   + bfgb_pkg::STORE_AW'(col_reg)
                   + bfgb_pkg::STORE_AW'({row_cw, {bfgb_pkg::GLYPH_SHIFT{1'b0}}});
        sx = {org_x_reg[bfgb_pkg::POS_W-1], org_x_reg}
           + $signed({1'b0, (bfgb_pkg::POS_W)'(col_reg)});
        sy = {org_y_reg[bfgb_pkg::POS_W-1], org_y_reg}
           + $signed({1'b0, (bfgb_pkg::POS_W)'(row_reg)});
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            font_mem[head.font_index] <= head.font_word;
        if (issue)
            rd_word_reg <= font_mem[glyph_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= issue;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_sx_reg      <= sx;
            b_sy_reg      <= sy;
            b_last_reg    <= pix_last;
            b_use_col_reg <= use_col_reg;
            b_colour_reg  <= colour_reg;
        end
    end

    // clip, visibility and framebuffer address
    always_comb
    begin
        on_x = !b_sx_reg[bfgb_pkg::POS_W]
             && (b_sx_reg[bfgb_pkg::POS_W-1:0] < bfgb_pkg::POS_W'(cfg.sw));
        on_y = !b_sy_reg[bfgb_pkg::POS_W]
             && (b_sy_reg[bfgb_pkg::POS_W-1:0] < bfgb_pkg::POS_W'(cfg.sh));
        vis  = on_x && on_y && (rd_word_reg[bfgb_pkg::COLOUR_BITS-1:0] != '0);
        prod = {{bfgb_pkg::SCR_W{1'b0}}, b_sy_reg[bfgb_pkg::SCR_W-1:0]}
             * {{bfgb_pkg::SCR_W{1'b0}}, cfg.sw};
        fb_sum = bfgb_pkg::FB_ADDR_W'(prod)
               + bfgb_pkg::FB_ADDR_W'(b_sx_reg[bfgb_pkg::SCR_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            we_reg   <= vis;
            addr_reg <= vis ? fb_sum : '0;
            if (!vis)
                pix_reg <= '0;
            else if (b_use_col_reg)
                pix_reg <= b_colour_reg;
            else
                pix_reg <= rd_word_reg;
            last_reg <= b_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign fb_address   = addr_reg;
    assign fb_pixel     = pix_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

FILE: hdl/bitmap_font_glyph_blitter_top.sv
// Draw item: queued, loaded into the back end's draw registers when popped, then each
// pixel passes the read stage and the output stage; one result per cycle while out_stall
// is low, char_width * char_height results; no other item is popped until the draw ends.
// Load item: written to the font store when popped, no result. A 2-entry queue sits
// between the sides. Reset: control, queue and cursor cleared, registers to their defaults;
// the font store is not cleared.
`default_nettype none

module bitmap_font_glyph_blitter_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                op,
    input  wire logic [bfgb_pkg::STORE_AW-1:0]       font_index,
    input  wire logic [bfgb_pkg::WORD_W-1:0]         font_word,
    input  wire logic [bfgb_pkg::CODE_W-1:0]         char_code,
    input  wire logic                                first_char,
    input  wire logic signed [bfgb_pkg::POS_W-1:0]   pos_x,
    input  wire logic signed [bfgb_pkg::POS_W-1:0]   pos_y,
    input  wire logic                                use_colour,
    input  wire logic [bfgb_pkg::WORD_W-1:0]         colour,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     write_enable,
    output logic [bfgb_pkg::FB_ADDR_W-1:0]           fb_address,
    output logic [bfgb_pkg::WORD_W-1:0]              fb_pixel,
    output logic                                     last,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bfgb_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [bfgb_pkg::PDATA_W-1:0]        pwdata,
    output logic [bfgb_pkg::PDATA_W-1:0]             prdata,
    output logic                                     pready
);

    logic [bfgb_pkg::CFG_CHAR_W-1:0] cw_raw_reg, ch_raw_reg;
    logic [bfgb_pkg::CFG_SCR_W-1:0]  sw_raw_reg, sh_raw_reg;
    bfgb_pkg::cfg_t     cfg;
    bfgb_pkg::reg_idx_t reg_sel;
    logic               cfg_write;

    bfgb_pkg::job_t front_job, head;
    logic           q_full, q_head_valid, q_pop, accept;

    assign pready    = 1'b1;
    assign reg_sel   = bfgb_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_raw_reg <= bfgb_pkg::RST_CHAR_WIDTH;
            ch_raw_reg <= bfgb_pkg::RST_CHAR_HEIGHT;
            sw_raw_reg <= bfgb_pkg::RST_SCREEN_WIDTH;
            sh_raw_reg <= bfgb_pkg::RST_SCREEN_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                bfgb_pkg::REG_CHAR_WIDTH:
                    cw_raw_reg <= pwdata[bfgb_pkg::CFG_CHAR_W-1:0];
                bfgb_pkg::REG_CHAR_HEIGHT:
                    ch_raw_reg <= pwdata[bfgb_pkg::CFG_CHAR_W-1:0];
                bfgb_pkg::REG_SCREEN_WIDTH:
                    sw_raw_reg <= pwdata[bfgb_pkg::CFG_SCR_W-1:0];
                bfgb_pkg::REG_SCREEN_HEIGHT:
                    sh_raw_reg <= pwdata[bfgb_pkg::CFG_SCR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            bfgb_pkg::REG_CHAR_WIDTH:    prdata = bfgb_pkg::PDATA_W'(cw_raw_reg);
            bfgb_pkg::REG_CHAR_HEIGHT:   prdata = bfgb_pkg::PDATA_W'(ch_raw_reg);
            bfgb_pkg::REG_SCREEN_WIDTH:  prdata = bfgb_pkg::PDATA_W'(sw_raw_reg);
            bfgb_pkg::REG_SCREEN_HEIGHT: prdata = bfgb_pkg::PDATA_W'(sh_raw_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.cw = bfgb_pkg::clamp_cw(cw_raw_reg);
        cfg.ch = bfgb_pkg::clamp_ch(ch_raw_reg);
        cfg.sw = bfgb_pkg::clamp_scr(sw_raw_reg);
        cfg.sh = bfgb_pkg::clamp_scr(sh_raw_reg);
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    bfgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .op         (op),
        .font_index (font_index),
        .font_word  (font_word),
        .char_code  (char_code),
        .first_char (first_char),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .use_colour (use_colour),
        .colour     (colour),
        .job        (front_job)
    );

    bfgb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_job   (front_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (head)
    );

    bfgb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (q_head_valid),
        .head         (head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .fb_address   (fb_address),
        .fb_pixel     (fb_pixel),
        .last         (last)
    );

endmodule

`default_nettype wire

FILE: hdl/bfgb_checker.sv
`default_nettype none

`include "bitmap_font_glyph_blitter_top_defines.svh"

module bfgb_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              write_enable,
    input wire logic [bfgb_pkg::FB_ADDR_W-1:0]    fb_address,
    input wire logic [bfgb_pkg::WORD_W-1:0]       fb_pixel,
    input wire logic                              last,
    input wire logic                              psel,
    input wire logic                              penable,
    input wire logic                              pready
);

    // a stalled result must not change
    `BFGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(write_enable) && $stable(fb_address) && $stable(fb_pixel) && $stable(last), "stalled result changed")

    // results without a write carry zero address and pixel
    `BFGB_ASSERT_NOW(a_nowrite_zero, out_valid && !write_enable, fb_address == '0 && fb_pixel == '0, "non-write result not zeroed")

    // a glyph run has no gaps until its last item
    `BFGB_ASSERT_NEXT(a_run_gapless, out_valid && !out_stall && !last, out_valid, "gap inside a glyph run")

    `BFGB_ASSERT_NOW(a_apb_ready, psel && penable, pready, "config access not ready")

endmodule

bind bitmap_font_glyph_blitter_top bfgb_checker u_bfgb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .fb_address   (fb_address),
    .fb_pixel     (fb_pixel),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pready       (pready)
);

`default_nettype wire
